@@ rtl/sfs_pkg.sv @@
// Shared types, codes and defaults of the sprite frame sequencer.
package sfs_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_ACC_BITS    = 24;

  localparam int POS_W  = 12;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_PAUSE  = 3'd3;
  localparam logic [2:0] ACT_RESUME = 3'd4;

  // play modes
  localparam logic [2:0] MODE_FWD_ONCE   = 3'd0;
  localparam logic [2:0] MODE_FWD_LOOP   = 3'd1;
  localparam logic [2:0] MODE_REV_ONCE   = 3'd2;
  localparam logic [2:0] MODE_REV_LOOP   = 3'd3;
  localparam logic [2:0] MODE_RANGE_ONCE = 3'd4;
  localparam logic [2:0] MODE_RANGE_LOOP = 3'd5;

  // register indexes
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_SHEET_COLUMNS = 3'd2;
  localparam logic [2:0] REG_SHEET_ROWS    = 3'd3;
  localparam logic [2:0] REG_PLAY_MODE     = 3'd4;
  localparam logic [2:0] REG_RANGE_START   = 3'd5;
  localparam logic [2:0] REG_RANGE_END     = 3'd6;
  localparam logic [2:0] REG_FRAME_PERIOD  = 3'd7;

  // register reset values
  localparam logic [9:0]  RST_FRAME_WIDTH   = 10'd1;
  localparam logic [9:0]  RST_FRAME_HEIGHT  = 10'd1;
  localparam logic [6:0]  RST_SHEET_COLUMNS = 7'd1;
  localparam logic [6:0]  RST_SHEET_ROWS    = 7'd1;
  localparam logic [2:0]  RST_PLAY_MODE     = MODE_FWD_LOOP;
  localparam logic [11:0] RST_RANGE_START   = 12'd0;
  localparam logic [12:0] RST_RANGE_END     = 13'd0;
  localparam logic [19:0] RST_FRAME_PERIOD  = 20'd33333;

  typedef struct packed {
    logic [2:0]  action;
    logic [19:0] elapsed_time;
  } in_word_t;

  typedef struct packed {
    logic [11:0] frame_index;
    logic [15:0] frame_x;
    logic [15:0] frame_y;
    logic        is_playing;
    logic        is_done;
  } out_word_t;

endpackage

@@ rtl/sprite_frame_sequencer_core.sv @@
// Sprite sheet frame sequencer: play state, timing and frame position lookup.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one word per action
//    (tick, start, stop, pause, resume); a tick carries elapsed microseconds.
//  - Output channel (out_valid / out_stall / out_data): exactly one word per
//    input word, giving frame index, pixel x/y, playing and done flags.
//  - APB port (psel .. pready): eight 32-bit registers at byte address 4*i; the user
//    must write them only while the block is idle (unenforced). pready is tied high.
//  - A word passes the states frame count, clamp, length, action, then, for a tick
//    while playing a non-empty list, accumulate and advance, then entry, map, divide,
//    x multiply, y multiply and output. One word is in flight at a time. The work is
//    set by the restoring divider that splits the NW-bit frame index into row and
//    column, one quotient bit per cycle (NW = column bits + row bits, 14 at default
//    sizes), and by the one multiplier shared for frame count, x and y.
//  - Reset (rst_n low, synchronous) restores register defaults and clears
//    position, accumulator and flags; no clearing pass is needed.
//  - A stalled result holds in the output register; the next word is taken
//    meanwhile and its result waits in the final state until the slot frees.
module sprite_frame_sequencer_core #(
  parameter int MAX_COLUMNS = sfs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = sfs_pkg::DEF_MAX_ROWS,
  parameter int ACC_BITS    = sfs_pkg::DEF_ACC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sfs_pkg::in_word_t           in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output sfs_pkg::out_word_t          out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfs_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfs_pkg::DATA_W-1:0]  pwdata,
  output logic [sfs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // register fields are 7 bits wide (at most 127), so the caps never exceed that
  localparam int COL_CAP = (MAX_COLUMNS < 127) ? MAX_COLUMNS : 127;
  localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int CW      = $clog2(COL_CAP + 1);
  localparam int RW      = $clog2(ROW_CAP + 1);
  localparam int NW      = CW + RW;
  localparam int PW      = sfs_pkg::POS_W;
  localparam int LW      = ((NW > PW) ? NW : PW) + 1;
  localparam int MW      = NW + 10;
  localparam int XW      = (MW > 16) ? MW : 16;
  localparam int CNTW    = $clog2(NW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NCNT,
    S_CLAMP,
    S_LEN,
    S_ACT,
    S_ACC,
    S_ADV,
    S_ENTRY,
    S_MAP,
    S_DIV,
    S_MULX,
    S_MULY,
    S_OUT
  } state_t;

  // configuration registers
  logic [9:0]  frame_width_r;
  logic [9:0]  frame_height_r;
  logic [6:0]  sheet_columns_r;
  logic [6:0]  sheet_rows_r;
  logic [2:0]  play_mode_r;
  logic [11:0] range_start_r;
  logic [12:0] range_end_r;
  logic [19:0] frame_period_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= sfs_pkg::RST_FRAME_WIDTH;
      frame_height_r  <= sfs_pkg::RST_FRAME_HEIGHT;
      sheet_columns_r <= sfs_pkg::RST_SHEET_COLUMNS;
      sheet_rows_r    <= sfs_pkg::RST_SHEET_ROWS;
      play_mode_r     <= sfs_pkg::RST_PLAY_MODE;
      range_start_r   <= sfs_pkg::RST_RANGE_START;
      range_end_r     <= sfs_pkg::RST_RANGE_END;
      frame_period_r  <= sfs_pkg::RST_FRAME_PERIOD;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        sfs_pkg::REG_FRAME_WIDTH:   frame_width_r   <= pwdata[9:0];
        sfs_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= pwdata[9:0];
        sfs_pkg::REG_SHEET_COLUMNS: sheet_columns_r <= pwdata[6:0];
        sfs_pkg::REG_SHEET_ROWS:    sheet_rows_r    <= pwdata[6:0];
        sfs_pkg::REG_PLAY_MODE:     play_mode_r     <= pwdata[2:0];
        sfs_pkg::REG_RANGE_START:   range_start_r   <= pwdata[11:0];
        sfs_pkg::REG_RANGE_END:     range_end_r     <= pwdata[12:0];
        sfs_pkg::REG_FRAME_PERIOD:  frame_period_r  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      sfs_pkg::REG_FRAME_WIDTH:   prdata = 32'(frame_width_r);
      sfs_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frame_height_r);
      sfs_pkg::REG_SHEET_COLUMNS: prdata = 32'(sheet_columns_r);
      sfs_pkg::REG_SHEET_ROWS:    prdata = 32'(sheet_rows_r);
      sfs_pkg::REG_PLAY_MODE:     prdata = 32'(play_mode_r);
      sfs_pkg::REG_RANGE_START:   prdata = 32'(range_start_r);
      sfs_pkg::REG_RANGE_END:     prdata = 32'(range_end_r);
      sfs_pkg::REG_FRAME_PERIOD:  prdata = 32'(frame_period_r);
      default:                    prdata = '0;
    endcase
  end

  // sequencer state and play state
  state_t              state_r, state_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic                playing_r, playing_nxt;
  logic                done_r, done_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;

  // per-word working registers (no reset)
  sfs_pkg::in_word_t   word_r, word_nxt;
  sfs_pkg::out_word_t  out_data_r, out_data_nxt;
  logic [2:0]          mode_r, mode_nxt;
  logic [CW-1:0]       cols_r, cols_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [NW-1:0]       s_r, s_nxt;
  logic [NW-1:0]       e_r, e_nxt;
  logic [NW-1:0]       len_r, len_nxt;
  logic [NW-1:0]       ns_r, ns_nxt;
  logic                sle_r, sle_nxt;
  logic [NW-1:0]       pc_r, pc_nxt;
  logic [PW-1:0]       idx_r, idx_nxt;
  logic [NW-1:0]       q_r, q_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [15:0]         x_r, x_nxt;
  logic [15:0]         y_r, y_nxt;

  // shared multiplier
  logic [NW-1:0] mul_a;
  logic [9:0]    mul_b;
  logic [MW-1:0] mul_p;
  logic [XW-1:0] mul_px;
  assign mul_p  = MW'(mul_a) * MW'(mul_b);
  assign mul_px = XW'(mul_p);

  // effective sheet size
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  always_comb begin
    if (sheet_columns_r == 7'd0) begin
      cols_eff = CW'(1);
    end else if (int'(sheet_columns_r) > COL_CAP) begin
      cols_eff = CW'(COL_CAP);
    end else begin
      cols_eff = CW'(sheet_columns_r);
    end
    if (sheet_rows_r == 7'd0) begin
      rows_eff = RW'(1);
    end else if (int'(sheet_rows_r) > ROW_CAP) begin
      rows_eff = RW'(ROW_CAP);
    end else begin
      rows_eff = RW'(sheet_rows_r);
    end
  end

  // divider step: one quotient bit per cycle
  logic [CW:0] div_trial;
  logic        div_ge;
  assign div_trial = {rem_r, q_r[NW-1]};
  assign div_ge    = div_trial >= {1'b0, cols_r};

  // wide helpers for the compare and subtract chains
  logic [LW-1:0]       pos_inc;
  logic [LW-1:0]       len_m1;
  logic [LW-1:0]       map_val;
  logic [ACC_BITS:0]   acc_sum;
  logic [ACC_BITS-1:0] period_eff;
  assign pos_inc    = LW'(pos_r) + LW'(1);
  assign len_m1     = LW'(len_r) - LW'(1);
  assign acc_sum    = (ACC_BITS+1)'(acc_r) + (ACC_BITS+1)'(word_r.elapsed_time);
  assign period_eff = (frame_period_r == 20'd0) ? ACC_BITS'(1) : ACC_BITS'(frame_period_r);

  always_comb begin
    if (len_r == '0) begin
      map_val = '0;
    end else if (mode_r < sfs_pkg::MODE_REV_ONCE) begin
      map_val = LW'(pc_r);
    end else if (mode_r < sfs_pkg::MODE_RANGE_ONCE) begin
      map_val = LW'(n_r) - LW'(1) - LW'(pc_r);
    end else if (sle_r || (pc_r < ns_r)) begin
      map_val = LW'(s_r) + LW'(pc_r);
    end else begin
      map_val = LW'(pc_r) - LW'(ns_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    playing_nxt   = playing_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    out_data_nxt  = out_data_r;
    mode_nxt      = mode_r;
    cols_nxt      = cols_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    len_nxt       = len_r;
    ns_nxt        = ns_r;
    sle_nxt       = sle_r;
    pc_nxt        = pc_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    mul_a         = '0;
    mul_b         = '0;

    // drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_data;
          state_nxt = S_NCNT;
        end
      end
      S_NCNT: begin
        // frame count through the shared multiplier
        mul_a     = NW'(cols_eff);
        mul_b     = 10'(rows_eff);
        n_nxt     = mul_p[NW-1:0];
        cols_nxt  = cols_eff;
        mode_nxt  = (play_mode_r > sfs_pkg::MODE_RANGE_LOOP) ? sfs_pkg::MODE_RANGE_LOOP
                                                            : play_mode_r;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        s_nxt     = (LW'(range_start_r) > LW'(n_r)) ? n_r : NW'(range_start_r);
        e_nxt     = (LW'(range_end_r) > LW'(n_r)) ? n_r : NW'(range_end_r);
        state_nxt = S_LEN;
      end
      S_LEN: begin
        sle_nxt = s_r < e_r;
        ns_nxt  = n_r - s_r;
        if (mode_r < sfs_pkg::MODE_RANGE_ONCE) begin
          len_nxt = n_r;
        end else if (s_r == e_r) begin
          len_nxt = '0;
        end else if (s_r < e_r) begin
          len_nxt = e_r - s_r;
        end else begin
          len_nxt = n_r - s_r + e_r;
        end
        state_nxt = S_ACT;
      end
      S_ACT: begin
        state_nxt = S_ENTRY;
        unique case (word_r.action)
          sfs_pkg::ACT_TICK: begin
            if (playing_r) begin
              if (len_r == '0) begin
                // empty list: behave as stop
                playing_nxt = 1'b0;
                pos_nxt     = '0;
              end else begin
                state_nxt = S_ACC;
              end
            end
          end
          sfs_pkg::ACT_START: begin
            if (len_r != '0) begin
              playing_nxt = 1'b1;
              done_nxt    = 1'b0;
              pos_nxt     = '0;
            end
          end
          sfs_pkg::ACT_STOP: begin
            playing_nxt = 1'b0;
            pos_nxt     = '0;
          end
          sfs_pkg::ACT_PAUSE:  playing_nxt = 1'b0;
          sfs_pkg::ACT_RESUME: playing_nxt = 1'b1;
          default: ;
        endcase
      end
      S_ACC: begin
        // saturate at the accumulator maximum
        acc_nxt   = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
        state_nxt = S_ADV;
      end
      S_ADV: begin
        if (acc_r >= period_eff) begin
          acc_nxt = acc_r - period_eff;
          if (pos_inc >= LW'(len_r)) begin
            if (mode_r[0]) begin
              pos_nxt = '0;
            end else begin
              pos_nxt     = len_m1[PW-1:0];
              playing_nxt = 1'b0;
              done_nxt    = 1'b1;
            end
          end else begin
            pos_nxt = pos_inc[PW-1:0];
          end
        end
        state_nxt = S_ENTRY;
      end
      S_ENTRY: begin
        // hold the last entry when the position ran past the list
        if (LW'(pos_r) >= LW'(len_r)) begin
          pc_nxt = len_m1[NW-1:0];
        end else begin
          pc_nxt = NW'(pos_r);
        end
        state_nxt = S_MAP;
      end
      S_MAP: begin
        idx_nxt   = map_val[PW-1:0];
        q_nxt     = map_val[NW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? CW'(div_trial - {1'b0, cols_r}) : div_trial[CW-1:0];
        q_nxt   = {q_r[NW-2:0], div_ge};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(NW - 1)) begin
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        mul_a     = NW'(rem_r);
        mul_b     = frame_width_r;
        x_nxt     = mul_px[15:0];
        state_nxt = S_MULY;
      end
      S_MULY: begin
        mul_a     = q_r;
        mul_b     = frame_height_r;
        y_nxt     = mul_px[15:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output slot to free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.frame_index = idx_r;
          out_data_nxt.frame_x     = x_r;
          out_data_nxt.frame_y     = y_r;
          out_data_nxt.is_playing  = playing_r;
          out_data_nxt.is_done     = done_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      acc_r       <= '0;
      playing_r   <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      playing_r   <= playing_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
    mode_r     <= mode_nxt;
    cols_r     <= cols_nxt;
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    len_r      <= len_nxt;
    ns_r       <= ns_nxt;
    sle_r      <= sle_nxt;
    pc_r       <= pc_nxt;
    idx_r      <= idx_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
  end

`ifndef ASSERT_OFF
  // an accepted word always starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_NCNT))
    else $error("accepted word did not start the sequencer");

  // a new result appears only from the final state
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the final state");

  // the partial remainder stays below the column count while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < cols_r))
    else $error("divider remainder out of range");
`endif

endmodule
